[design/qpgc_pkg.sv]
// ----------------------------------------------------------------------------
// qpgc_pkg: shared types and constants for the quad pixel glyph classifier
// Beat payload structs, glyph codes and the widths used by the lanes.
// ----------------------------------------------------------------------------
package qpgc_pkg;

   localparam int unsigned COLOR_W   = 8;
   localparam int unsigned SQ_W      = 2 * COLOR_W;        // squared difference
   localparam int unsigned WEIGHT_W  = 10;                 // 512+m and 767-m
   localparam int unsigned PROD_W    = WEIGHT_W + SQ_W;    // weighted square
   localparam int unsigned DIST_W    = PROD_W + 2;         // three-term sum
   localparam int unsigned LANE_DEPTH = 4;                 // lane pipeline stages
   localparam int unsigned PIPE_DEPTH = LANE_DEPTH + 1;    // plus merge stage

   localparam logic [COLOR_W-1:0] THRESHOLD_RESET = 8'd10;

   // glyph codes
   localparam logic [3:0] GLYPH_SPACE      = 4'd0;
   localparam logic [3:0] GLYPH_UPPER      = 4'd1;
   localparam logic [3:0] GLYPH_LOWER      = 4'd2;
   localparam logic [3:0] GLYPH_LEFT       = 4'd3;
   localparam logic [3:0] GLYPH_RIGHT      = 4'd4;
   localparam logic [3:0] GLYPH_Q_UL_LL_LR = 4'd5;
   localparam logic [3:0] GLYPH_Q_UL_UR_LR = 4'd6;
   localparam logic [3:0] GLYPH_Q_UR_LL_LR = 4'd7;
   localparam logic [3:0] GLYPH_Q_UL_UR_LL = 4'd8;
   localparam logic [3:0] GLYPH_DIAG_UL_LR = 4'd9;
   localparam logic [3:0] GLYPH_DIAG_UR_LL = 4'd10;

   typedef enum logic [1:0] {
      PIX_A = 2'd0,
      PIX_B = 2'd1,
      PIX_C = 2'd2,
      PIX_D = 2'd3
   } pix_sel_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [7:0] a_red;
      logic [7:0] a_green;
      logic [7:0] a_blue;
      logic [7:0] b_red;
      logic [7:0] b_green;
      logic [7:0] b_blue;
      logic [7:0] c_red;
      logic [7:0] c_green;
      logic [7:0] c_blue;
      logic [7:0] d_red;
      logic [7:0] d_green;
      logic [7:0] d_blue;
   } req_type;

   typedef struct packed {
      logic [3:0] glyph;
      logic       unmatched;
      logic [7:0] fore_red;
      logic [7:0] fore_green;
      logic [7:0] fore_blue;
      logic [7:0] back_red;
      logic [7:0] back_green;
      logic [7:0] back_blue;
   } rsp_type;

   // same-color flags of the six pixel pairs
   typedef struct packed {
      logic ab;
      logic cd;
      logic ac;
      logic bd;
      logic ad;
      logic bc;
   } pair_match_type;

endpackage

[design/qpgc_lane.sv]
// ----------------------------------------------------------------------------
// qpgc_lane: redmean same-color compare of one pixel pair
// Four-stage pipeline: differences, squares, weighted products, sum+compare.
// ----------------------------------------------------------------------------
module qpgc_lane
   import qpgc_pkg::*;
(
   input  logic              clock,
   input  pixel_type         pix_p,
   input  pixel_type         pix_q,
   input  logic [SQ_W-1:0]   thr_sq,
   output logic              same
);

   logic [COLOR_W-1:0]  dr_ff, dg_ff, db_ff;
   logic [COLOR_W-1:0]  dr_in, dg_in, db_in;
   logic [WEIGHT_W-1:0] wr1_ff, wb1_ff, wr1_in, wb1_in;
   logic [COLOR_W:0]    sum_r;
   logic [COLOR_W-1:0]  mean_r;
   logic [SQ_W-1:0]     sqr_ff, sqg_ff, sqb_ff;
   logic [WEIGHT_W-1:0] wr2_ff, wb2_ff;
   logic [PROD_W-1:0]   pr_ff, pg_ff, pb_ff;
   logic [DIST_W-1:0]   dist_sum;
   logic [DIST_W-1:0]   limit;
   logic                same_ff;

   // stage 1: absolute differences and red mean weights
   always_comb begin
      dr_in  = (pix_p.red   > pix_q.red)   ? pix_p.red   - pix_q.red
                                           : pix_q.red   - pix_p.red;
      dg_in  = (pix_p.green > pix_q.green) ? pix_p.green - pix_q.green
                                           : pix_q.green - pix_p.green;
      db_in  = (pix_p.blue  > pix_q.blue)  ? pix_p.blue  - pix_q.blue
                                           : pix_q.blue  - pix_p.blue;
      sum_r  = {1'b0, pix_p.red} + {1'b0, pix_q.red};
      mean_r = sum_r[COLOR_W:1];
      wr1_in = 10'd512 + {2'b00, mean_r};
      wb1_in = 10'd767 - {2'b00, mean_r};
   end

   always_ff @(posedge clock) begin
      dr_ff  <= dr_in;
      dg_ff  <= dg_in;
      db_ff  <= db_in;
      wr1_ff <= wr1_in;
      wb1_ff <= wb1_in;
   end

   // stage 2: squares
   always_ff @(posedge clock) begin
      sqr_ff <= dr_ff * dr_ff;
      sqg_ff <= dg_ff * dg_ff;
      sqb_ff <= db_ff * db_ff;
      wr2_ff <= wr1_ff;
      wb2_ff <= wb1_ff;
   end

   // stage 3: weighted terms, green weight is a plain shift
   always_ff @(posedge clock) begin
      pr_ff <= wr2_ff * sqr_ff;
      pg_ff <= {sqg_ff, 10'b0};
      pb_ff <= wb2_ff * sqb_ff;
   end

   // stage 4: sum and compare against 256*t*t
   always_comb begin
      dist_sum = {2'b00, pr_ff} + {2'b00, pg_ff} + {2'b00, pb_ff};
      limit    = {4'b0000, thr_sq, 8'b0};
   end

   always_ff @(posedge clock) begin
      same_ff <= (dist_sum < limit);
   end

   assign same = same_ff;

endmodule

[design/qpgc_merge.sv]
// ----------------------------------------------------------------------------
// qpgc_merge: glyph priority tree and color pick
// Combines the six pair flags into a glyph and registers the result beat.
// ----------------------------------------------------------------------------
module qpgc_merge
   import qpgc_pkg::*;
(
   input  logic           clock,
   input  pair_match_type match,
   input  req_type        pix,
   output rsp_type        rsp
);

   logic [3:0]  glyph;
   logic        unmatched;
   pix_sel_type fore_sel, back_sel;
   pixel_type   fore_px, back_px;
   rsp_type     rsp_ff, rsp_in;

   function automatic pixel_type pick(input req_type p, input pix_sel_type sel);
      pixel_type r;
      case (sel)
         PIX_A:   r = '{red: p.a_red, green: p.a_green, blue: p.a_blue};
         PIX_B:   r = '{red: p.b_red, green: p.b_green, blue: p.b_blue};
         PIX_C:   r = '{red: p.c_red, green: p.c_green, blue: p.c_blue};
         PIX_D:   r = '{red: p.d_red, green: p.d_green, blue: p.d_blue};
         default: r = '{red: p.a_red, green: p.a_green, blue: p.a_blue};
      endcase
      return r;
   endfunction

   // priority tree
   always_comb begin
      glyph     = GLYPH_SPACE;
      unmatched = 1'b0;
      fore_sel  = PIX_A;
      back_sel  = PIX_A;
      if ((match.ab && match.cd && match.ac) || (match.ad && match.bc) ||
          (match.ac && match.bd) || (match.ab && match.cd) ||
          (match.bc && match.cd && match.ac) || (match.ab && match.bc && match.cd)) begin
         glyph = GLYPH_SPACE;
      end else if (match.ab && !match.cd) begin
         glyph = GLYPH_UPPER; back_sel = PIX_C; fore_sel = PIX_A;
      end else if (match.cd && !match.ab && !match.ac && !match.bd) begin
         glyph = GLYPH_LOWER; back_sel = PIX_A; fore_sel = PIX_C;
      end else if (match.ac && !match.bd && !match.ab && !match.cd) begin
         glyph = GLYPH_LEFT; back_sel = PIX_B; fore_sel = PIX_C;
      end else if (match.bd && !match.ac && !match.ab && !match.cd) begin
         glyph = GLYPH_RIGHT; back_sel = PIX_A; fore_sel = PIX_B;
      end else if (match.ac && match.cd && !match.ab && !match.bc) begin
         glyph = GLYPH_Q_UL_LL_LR; back_sel = PIX_B; fore_sel = PIX_C;
      end else if (match.ab && match.bd && !match.ac && !match.cd) begin
         glyph = GLYPH_Q_UL_UR_LR; back_sel = PIX_C; fore_sel = PIX_D;
      end else if (match.cd && match.bd && !match.ac && !match.ab) begin
         glyph = GLYPH_Q_UR_LL_LR; back_sel = PIX_A; fore_sel = PIX_C;
      end else if (match.ab && match.ac && !match.bd && !match.cd) begin
         glyph = GLYPH_Q_UL_UR_LL; back_sel = PIX_D; fore_sel = PIX_C;
      end else if (match.ad && !match.ab && !match.bd && !match.bc) begin
         glyph = GLYPH_DIAG_UL_LR; back_sel = PIX_B; fore_sel = PIX_A;
      end else if (match.bc && !match.ab && !match.cd && !match.ac) begin
         glyph = GLYPH_DIAG_UR_LL; back_sel = PIX_A; fore_sel = PIX_C;
      end else begin
         unmatched = 1'b1;
      end
   end

   // color pick and result beat
   always_comb begin
      fore_px           = pick(pix, fore_sel);
      back_px           = pick(pix, back_sel);
      rsp_in.glyph      = glyph;
      rsp_in.unmatched  = unmatched;
      rsp_in.fore_red   = fore_px.red;
      rsp_in.fore_green = fore_px.green;
      rsp_in.fore_blue  = fore_px.blue;
      rsp_in.back_red   = back_px.red;
      rsp_in.back_green = back_px.green;
      rsp_in.back_blue  = back_px.blue;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

[design/quad_pixel_glyph_classifier.sv]
// Path: the start beat runs through the lane pipeline and the merge stage to the rsp_strobe beat.
// Throughput: one 2x2 block per cycle; busy is always low, the six
//   distance lanes and the merge stage are fully pipelined.
// Reset: synchronous, active high; clears the strobe pipeline and sets the
//   threshold to 10. The receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
// quad_pixel_glyph_classifier: 2x2 pixel block to character glyph
// Six parallel redmean compare lanes feed a priority merge stage.
// ----------------------------------------------------------------------------
module quad_pixel_glyph_classifier
   import qpgc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   input  logic               csr_write_enable,
   input  logic [COLOR_W-1:0] csr_write_data
);

   logic [SQ_W-1:0]       thr_sq_ff;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   req_type               pix_ff [LANE_DEPTH];
   pixel_type             px_a, px_b, px_c, px_d;
   pair_match_type        match;

   assign busy = 1'b0;

   // threshold kept squared; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_sq_ff <= SQ_W'(THRESHOLD_RESET) * SQ_W'(THRESHOLD_RESET);
      end else if (csr_write_enable) begin
         thr_sq_ff <= SQ_W'(csr_write_data) * SQ_W'(csr_write_data);
      end
   end

   // beat valid pipeline
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // pixel delay line aligned with lane outputs
   always_ff @(posedge clock) begin
      pix_ff[0] <= req_data;
      for (int i = 1; i < LANE_DEPTH; i++) begin
         pix_ff[i] <= pix_ff[i-1];
      end
   end

   assign px_a = '{red: req_data.a_red, green: req_data.a_green, blue: req_data.a_blue};
   assign px_b = '{red: req_data.b_red, green: req_data.b_green, blue: req_data.b_blue};
   assign px_c = '{red: req_data.c_red, green: req_data.c_green, blue: req_data.c_blue};
   assign px_d = '{red: req_data.d_red, green: req_data.d_green, blue: req_data.d_blue};

   // six compare lanes
   qpgc_lane u_lane_ab (.clock(clock), .pix_p(px_a), .pix_q(px_b), .thr_sq(thr_sq_ff),
                        .same(match.ab));
   qpgc_lane u_lane_cd (.clock(clock), .pix_p(px_c), .pix_q(px_d), .thr_sq(thr_sq_ff),
                        .same(match.cd));
   qpgc_lane u_lane_ac (.clock(clock), .pix_p(px_a), .pix_q(px_c), .thr_sq(thr_sq_ff),
                        .same(match.ac));
   qpgc_lane u_lane_bd (.clock(clock), .pix_p(px_b), .pix_q(px_d), .thr_sq(thr_sq_ff),
                        .same(match.bd));
   qpgc_lane u_lane_ad (.clock(clock), .pix_p(px_a), .pix_q(px_d), .thr_sq(thr_sq_ff),
                        .same(match.ad));
   qpgc_lane u_lane_bc (.clock(clock), .pix_p(px_b), .pix_q(px_c), .thr_sq(thr_sq_ff),
                        .same(match.bc));

   // merge stage
   qpgc_merge u_merge (
      .clock (clock),
      .match (match),
      .pix   (pix_ff[LANE_DEPTH-1]),
      .rsp   (rsp_data)
   );

   assign rsp_strobe = vld_ff[PIPE_DEPTH-1];

endmodule
